// ----- src/ihq_pkg.sv -----
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types, sizes and codes of the indexed max-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int VALUE_BITS = 17;
    localparam int HANDLES    = 1024;
    localparam int HANDLE_W   = $clog2(HANDLES);
    localparam int COUNT_W    = 11;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;

    // Datapath operations issued by the controller, one per cycle.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR       = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD        = 5'd2;
    localparam logic [OP_W-1:0] OP_SET_FULL    = 5'd3;
    localparam logic [OP_W-1:0] OP_SET_EMPTY   = 5'd4;
    localparam logic [OP_W-1:0] OP_SET_ABSENT  = 5'd5;
    localparam logic [OP_W-1:0] OP_SET_DUP     = 5'd6;
    localparam logic [OP_W-1:0] OP_RD_ROOT     = 5'd7;
    localparam logic [OP_W-1:0] OP_INS_COMMIT  = 5'd8;
    localparam logic [OP_W-1:0] OP_RD_PARENT   = 5'd9;
    localparam logic [OP_W-1:0] OP_WR_CUR      = 5'd10;
    localparam logic [OP_W-1:0] OP_MOVE_PARENT = 5'd11;
    localparam logic [OP_W-1:0] OP_DEL_IDX     = 5'd12;
    localparam logic [OP_W-1:0] OP_LD_CUR      = 5'd13;
    localparam logic [OP_W-1:0] OP_REMOVE      = 5'd14;
    localparam logic [OP_W-1:0] OP_RD_LAST     = 5'd15;
    localparam logic [OP_W-1:0] OP_RD_LEFT     = 5'd16;
    localparam logic [OP_W-1:0] OP_LATCH_LEFT  = 5'd17;
    localparam logic [OP_W-1:0] OP_MOVE_BEST   = 5'd18;
    localparam logic [OP_W-1:0] OP_TOP         = 5'd19;
    localparam logic [OP_W-1:0] OP_OUT_LOAD    = 5'd20;

    typedef logic [OP_W-1:0] op_t;

    typedef struct packed {
        logic [1:0]            command;
        logic [VALUE_BITS-1:0] value;
        logic [HANDLE_W-1:0]   handle;
    } ihq_in_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [VALUE_BITS-1:0] removed_value;
        logic [HANDLE_W-1:0]   removed_handle;
        logic                  top_valid;
        logic [VALUE_BITS-1:0] top_value;
        logic [COUNT_W-1:0]    count;
    } ihq_out_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [HANDLE_W-1:0]   handle;
    } entry_t;

    typedef struct packed {
        logic              present;
        logic [ADDR_W-1:0] pos;
    } pos_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       dup;
        logic       absent;
        logic       idx_zero;
        logic       up_stop;
        logic       l_ok;
        logic       best_cur;
        logic       clr_last;
    } ihq_flags_t;

endpackage

// ----- src/ihq_ram.sv -----
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/ihq_dp.sv -----
// ----------------------------------------------------------------------------
// ihq_dp
// Heap datapath: entry and position memories, working registers, result word.
// ----------------------------------------------------------------------------
module ihq_dp
    import ihq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  ihq_in_t    req,
    output ihq_flags_t flags,
    output ihq_out_t   rsp
);

    logic [1:0]            cmd_reg, cmd_next;
    entry_t                cur_reg, cur_next;
    entry_t                rem_reg, rem_next;
    entry_t                left_reg, left_next;
    logic                  r_ok_reg, r_ok_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [2:0]            status_reg, status_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic [HANDLE_W-1:0]   clr_reg, clr_next;
    ihq_out_t              rsp_reg, rsp_next;

    logic                heap_we;
    logic [ADDR_W-1:0]   heap_waddr, heap_raddr;
    entry_t              heap_wdata, heap_rdata;
    logic                pos_we;
    logic [HANDLE_W-1:0] pos_waddr;
    pos_t                pos_wdata, pos_rdata;

    logic [ADDR_W-1:0] parent;
    logic [ADDR_W:0]   lchild;
    logic [ADDR_W+1:0] rchild;
    logic              left_gt, right_gt;
    entry_t            best_lc, best;
    logic [ADDR_W-1:0] best_idx;

    ihq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    ihq_ram #(.WIDTH($bits(pos_t)), .DEPTH(HANDLES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (cur_reg.handle),
        .rdata (pos_rdata)
    );

    assign parent = ADDR_W'((idx_reg - ADDR_W'(1)) >> 1);
    assign lchild = {idx_reg, 1'b1};
    assign rchild = {1'b0, lchild} + (ADDR_W+2)'(1);

    // The moving entry stays in cur_reg; children are compared against it.
    assign left_gt  = left_reg.value > cur_reg.value;
    assign best_lc  = left_gt ? left_reg : cur_reg;
    assign right_gt = r_ok_reg && (heap_rdata.value > best_lc.value);
    assign best     = right_gt ? heap_rdata : left_reg;
    assign best_idx = right_gt ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];

    always_comb
    begin
        flags.cmd      = cmd_reg;
        flags.full     = count_reg == COUNT_W'(DEPTH);
        flags.empty    = count_reg == '0;
        flags.dup      = pos_rdata.present;
        flags.absent   = !pos_rdata.present || ({1'b0, pos_rdata.pos} >= count_reg);
        flags.idx_zero = idx_reg == '0;
        flags.up_stop  = cur_reg.value <= heap_rdata.value;
        flags.l_ok     = COUNT_W'(lchild) < count_reg;
        flags.best_cur = !left_gt && !right_gt;
        flags.clr_last = clr_reg == {HANDLE_W{1'b1}};
    end

    always_comb
    begin
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = cur_reg;
        pos_we     = 1'b0;
        pos_waddr  = cur_reg.handle;
        pos_wdata  = '{present: 1'b1, pos: idx_reg};
        unique case (op)
            OP_RD_PARENT:  heap_raddr = parent;
            OP_DEL_IDX:    heap_raddr = pos_rdata.pos;
            OP_RD_LAST:    heap_raddr = count_reg[ADDR_W-1:0];
            OP_RD_LEFT:    heap_raddr = lchild[ADDR_W-1:0];
            OP_LATCH_LEFT: heap_raddr = rchild[ADDR_W-1:0];
            OP_WR_CUR:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            OP_MOVE_PARENT:
            begin
                heap_we    = 1'b1;
                heap_wdata = heap_rdata;
                pos_we     = 1'b1;
                pos_waddr  = heap_rdata.handle;
            end
            OP_MOVE_BEST:
            begin
                heap_we    = 1'b1;
                heap_wdata = best;
                pos_we     = 1'b1;
                pos_waddr  = best.handle;
            end
            OP_REMOVE:
            begin
                pos_we    = 1'b1;
                pos_wdata = '0;
            end
            OP_CLEAR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
            end
            default: heap_raddr = '0;
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        left_next   = left_reg;
        r_ok_next   = r_ok_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        top_next    = top_reg;
        clr_next    = clr_reg;
        rsp_next    = rsp_reg;
        unique case (op)
            OP_CLEAR:      clr_next = clr_reg + HANDLE_W'(1);
            OP_LOAD:
            begin
                cmd_next    = req.command;
                cur_next    = '{value: req.value, handle: req.handle};
                rem_next    = '0;
                idx_next    = count_reg[ADDR_W-1:0];
                status_next = ST_OK;
            end
            OP_SET_FULL:    status_next = ST_FULL;
            OP_SET_EMPTY:   status_next = ST_EMPTY;
            OP_SET_ABSENT:  status_next = ST_ABSENT;
            OP_SET_DUP:     status_next = ST_DUP;
            OP_INS_COMMIT:  count_next  = count_reg + COUNT_W'(1);
            OP_MOVE_PARENT: idx_next    = parent;
            OP_DEL_IDX:     idx_next    = pos_rdata.pos;
            OP_LD_CUR:      cur_next    = heap_rdata;
            OP_REMOVE:
            begin
                rem_next   = cur_reg;
                count_next = count_reg - COUNT_W'(1);
                idx_next   = '0;
            end
            OP_LATCH_LEFT:
            begin
                left_next = heap_rdata;
                r_ok_next = rchild < (ADDR_W+2)'(count_reg);
            end
            OP_MOVE_BEST:   idx_next = best_idx;
            OP_TOP:         top_next = (count_reg == '0) ? '0 : heap_rdata.value;
            OP_OUT_LOAD:
            begin
                rsp_next.status         = status_reg;
                rsp_next.removed_value  = rem_reg.value;
                rsp_next.removed_handle = rem_reg.handle;
                rsp_next.top_valid      = count_reg != '0;
                rsp_next.top_value      = top_reg;
                rsp_next.count          = count_reg;
            end
            default:        cmd_next = cmd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        left_reg   <= left_next;
        r_ok_reg   <= r_ok_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// ----- src/ihq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihq_ctrl
// Sequencer for the heap commands; drives one datapath operation per cycle.
// ----------------------------------------------------------------------------
module ihq_ctrl
    import ihq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  ihq_flags_t flags,
    output op_t        op
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_INS_CHK  = 5'd3;
    localparam logic [4:0] S_UP_TEST  = 5'd4;
    localparam logic [4:0] S_UP_CMP   = 5'd5;
    localparam logic [4:0] S_DEL_CHK  = 5'd6;
    localparam logic [4:0] S_DEL_LD   = 5'd7;
    localparam logic [4:0] S_ROOT_LD  = 5'd8;
    localparam logic [4:0] S_REM      = 5'd9;
    localparam logic [4:0] S_EXT_LAST = 5'd10;
    localparam logic [4:0] S_LAST_LD  = 5'd11;
    localparam logic [4:0] S_DN_L     = 5'd12;
    localparam logic [4:0] S_DN_R     = 5'd13;
    localparam logic [4:0] S_DN_CMP   = 5'd14;
    localparam logic [4:0] S_TOP      = 5'd15;
    localparam logic [4:0] S_TOP_LD   = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (flags.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (flags.cmd == CMD_INSERT)
                begin
                    if (flags.full)
                    begin
                        op         = OP_SET_FULL;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        state_next = S_INS_CHK;
                    end
                end
                else if (flags.cmd == CMD_EXTRACT)
                begin
                    if (flags.empty)
                    begin
                        op         = OP_SET_EMPTY;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        op         = OP_RD_ROOT;
                        state_next = S_ROOT_LD;
                    end
                end
                else if (flags.cmd == CMD_DELETE)
                begin
                    state_next = S_DEL_CHK;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_INS_CHK:
            begin
                if (flags.dup)
                begin
                    op         = OP_SET_DUP;
                    state_next = S_TOP;
                end
                else
                begin
                    op         = OP_INS_COMMIT;
                    state_next = S_UP_TEST;
                end
            end
            S_UP_TEST:
            begin
                if (flags.idx_zero)
                begin
                    if (flags.cmd == CMD_DELETE)
                    begin
                        state_next = S_REM;
                    end
                    else
                    begin
                        op         = OP_WR_CUR;
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    op         = OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (flags.cmd == CMD_INSERT && flags.up_stop)
                begin
                    op         = OP_WR_CUR;
                    state_next = S_TOP;
                end
                else
                begin
                    op         = OP_MOVE_PARENT;
                    state_next = S_UP_TEST;
                end
            end
            S_DEL_CHK:
            begin
                if (flags.absent)
                begin
                    op         = OP_SET_ABSENT;
                    state_next = S_TOP;
                end
                else
                begin
                    op         = OP_DEL_IDX;
                    state_next = S_DEL_LD;
                end
            end
            S_DEL_LD:
            begin
                op         = OP_LD_CUR;
                state_next = S_UP_TEST;
            end
            S_ROOT_LD:
            begin
                op         = OP_LD_CUR;
                state_next = S_REM;
            end
            S_REM:
            begin
                op         = OP_REMOVE;
                state_next = S_EXT_LAST;
            end
            S_EXT_LAST:
            begin
                if (flags.empty)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    op         = OP_RD_LAST;
                    state_next = S_LAST_LD;
                end
            end
            S_LAST_LD:
            begin
                op         = OP_LD_CUR;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (flags.l_ok)
                begin
                    op         = OP_RD_LEFT;
                    state_next = S_DN_R;
                end
                else
                begin
                    op         = OP_WR_CUR;
                    state_next = S_TOP;
                end
            end
            S_DN_R:
            begin
                op         = OP_LATCH_LEFT;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (flags.best_cur)
                begin
                    op         = OP_WR_CUR;
                    state_next = S_TOP;
                end
                else
                begin
                    op         = OP_MOVE_BEST;
                    state_next = S_DN_L;
                end
            end
            S_TOP:
            begin
                op         = OP_RD_ROOT;
                state_next = S_TOP_LD;
            end
            S_TOP_LD:
            begin
                op         = OP_TOP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    op         = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (op == OP_OUT_LOAD)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/indexed_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Indexed binary max-heap with insert, extract-maximum and delete-by-handle.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every entry of the handle
// position memory and holds req_stall high until it ends. Each command word
// is then processed alone: the controller steps through the heap with one
// write of the entry memory per level and one read per level while rising,
// two while sinking, since both memories have a single write port and a
// single registered read port. Insert lets the new entry rise toward the
// root. Extract moves the former last entry to the root and lets it sink.
// Delete forces the named entry up to the root, removes it there and then
// sinks the former last entry. A full or empty failure and an unused command
// code end at dispatch, a duplicate or absent handle at the check after it.
// The controller returns to idle before the next word is taken. The result
// word waits in an output register; the next command is accepted as soon as
// that result is loaded, even while the result is still stalled downstream.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue
    import ihq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ihq_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ihq_out_t rsp
);

    // The controller sees only decoded flags from the datapath, and the
    // datapath performs exactly one operation per cycle as told.
    ihq_flags_t flags;
    op_t        op;

    ihq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .flags     (flags),
        .op        (op)
    );

    // Entries are kept in array order of the heap; the moving entry is held
    // in a register so each level costs one move instead of a full swap.
    ihq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .req   (req),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

// ----- tb/ihq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_checker
// Watches both channels of the heap queue, keeps its own copy of the heap,
// predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module ihq_checker
    import ihq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  ihq_in_t  req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  ihq_out_t rsp,
    output int       fail_count,
    output int       pending
);

    logic [VALUE_BITS-1:0] heap_val [DEPTH];
    logic [HANDLE_W-1:0]   heap_hnd [DEPTH];
    int                    slot_of  [HANDLES];
    bit                    is_held  [HANDLES];
    int                    fill;
    ihq_out_t              expected_words [$];

    initial begin
        fail_count = 0;
        fill       = 0;
        for (int i = 0; i < HANDLES; i++) begin
            slot_of[i] = 0;
            is_held[i] = 0;
        end
    end

    assign pending = expected_words.size();

    function automatic void swap_slots(int a, int b);
        logic [VALUE_BITS-1:0] v;
        logic [HANDLE_W-1:0]   h;
        v = heap_val[a];
        h = heap_hnd[a];
        heap_val[a] = heap_val[b];
        heap_hnd[a] = heap_hnd[b];
        heap_val[b] = v;
        heap_hnd[b] = h;
        slot_of[heap_hnd[a]] = a;
        slot_of[heap_hnd[b]] = b;
    endfunction

    function automatic void rise(int i, bit forced);
        int p;
        while (i > 0) begin
            p = (i - 1) >> 1;
            if (!forced && heap_val[i] <= heap_val[p])
                return;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sink(int i);
        int big;
        while (i < fill) begin
            big = i;
            if (2 * i + 1 < fill && heap_val[2 * i + 1] > heap_val[big])
                big = 2 * i + 1;
            if (2 * i + 2 < fill && heap_val[2 * i + 2] > heap_val[big])
                big = 2 * i + 2;
            if (big == i)
                return;
            swap_slots(i, big);
            i = big;
        end
    endfunction

    function automatic void pop_root(ref ihq_out_t w);
        w.removed_value  = heap_val[0];
        w.removed_handle = heap_hnd[0];
        is_held[heap_hnd[0]] = 0;
        fill--;
        if (fill == 0)
            return;
        heap_val[0] = heap_val[fill];
        heap_hnd[0] = heap_hnd[fill];
        slot_of[heap_hnd[0]] = 0;
        sink(0);
    endfunction

    function automatic ihq_out_t heap_step(ihq_in_t c);
        ihq_out_t w;
        w = '0;
        w.status = ST_OK;
        case (c.command)
            CMD_INSERT: begin
                if (fill >= DEPTH)
                    w.status = ST_FULL;
                else if (is_held[c.handle])
                    w.status = ST_DUP;
                else begin
                    heap_val[fill]    = c.value;
                    heap_hnd[fill]    = c.handle;
                    slot_of[c.handle] = fill;
                    is_held[c.handle] = 1;
                    fill++;
                    rise(fill - 1, 0);
                end
            end
            CMD_EXTRACT: begin
                if (fill == 0)
                    w.status = ST_EMPTY;
                else
                    pop_root(w);
            end
            CMD_DELETE: begin
                if (!is_held[c.handle] || slot_of[c.handle] >= fill)
                    w.status = ST_ABSENT;
                else begin
                    rise(slot_of[c.handle], 1);
                    pop_root(w);
                end
            end
            default: ;
        endcase
        w.top_valid = (fill > 0);
        w.top_value = (fill > 0) ? heap_val[0] : '0;
        w.count     = fill[COUNT_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: result word field %s mismatch: got %0d, want %0d",
                 $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk) begin
        ihq_out_t want;
        if (rst_n) begin
            // A result can never belong to the command taken at the same edge,
            // so results are checked before the new command is predicted.
            if (rsp_valid && !rsp_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("presence", 1, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.removed_value !== want.removed_value)
                        report_mismatch("removed_value", rsp.removed_value,
                                        want.removed_value);
                    if (rsp.removed_handle !== want.removed_handle)
                        report_mismatch("removed_handle", rsp.removed_handle,
                                        want.removed_handle);
                    if (rsp.top_valid !== want.top_valid)
                        report_mismatch("top_valid", rsp.top_valid, want.top_valid);
                    if (rsp.top_value !== want.top_value)
                        report_mismatch("top_value", rsp.top_value, want.top_value);
                    if (rsp.count !== want.count)
                        report_mismatch("count", rsp.count, want.count);
                end
            end
            if (req_valid && !req_stall)
                expected_words.push_back(heap_step(req));
        end
    end

endmodule

// ----- tb/indexed_max_heap_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_tb
// Drives command words into the heap queue with bursty timing and a stalling
// receiver; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_tb;
    import ihq_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    ihq_in_t  req;
    logic     rsp_valid;
    logic     rsp_stall;
    ihq_out_t rsp;

    int fail_count;
    int pending;

    // Sender burst bookkeeping and the request for a long receiver hold-off.
    int burst_left;
    bit hold_off_request;

    indexed_max_heap_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    ihq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offers one command word. The payload and valid change only at the
    // falling edge; the word counts as taken at the first rising edge that
    // sees stall low. Between bursts valid drops for a random number of
    // cycles, so gaps land on every phase of the block's work.
    task automatic send_word(logic [1:0] cmd, logic [VALUE_BITS-1:0] val,
                             logic [HANDLE_W-1:0] hnd);
        @(negedge clk);
        if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        req_valid <= 1'b1;
        req       <= '{command: cmd, value: val, handle: hnd};
        burst_left--;
        do @(posedge clk); while (req_stall);
    endtask

    // Receiver: random segments of never, sometimes or mostly stalling. When
    // the sender asks for it, one long hold-off lets the output register and
    // then the input side back up.
    initial begin
        int seg_len;
        int mode;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 0;
                for (int n = 0; n < 400; n++) begin
                    @(negedge clk);
                    rsp_stall <= 1'b1;
                end
            end
            seg_len = $urandom_range(1, 60);
            mode    = $urandom_range(0, 2);
            for (int n = 0; n < seg_len; n++) begin
                @(negedge clk);
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // A hard limit well beyond the slowest legal run, including the clearing
    // pass after reset.
    initial begin
        #20000000;
        $display("indexed_max_heap_queue regression: fail");
        $finish;
    end

    initial begin
        int r;
        logic [HANDLE_W-1:0] h;
        req_valid        = 1'b0;
        req              = '0;
        burst_left       = 0;
        hold_off_request = 0;
        rst_n            = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: empty heap failures, an unused command code, value
        // extremes, equal values, a duplicate handle, a delete that forces an
        // entry up past larger parents, and a repeated delete of a gone handle.
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_DELETE, '0, 10'd7);
        send_word(CMD_UNUSED, 17'h1ffff, 10'h3ff);
        send_word(CMD_INSERT, 17'd0, 10'd0);
        send_word(CMD_INSERT, 17'h1ffff, 10'h3ff);
        send_word(CMD_INSERT, 17'h1ffff, 10'd512);
        send_word(CMD_INSERT, 17'd5, 10'd0);
        send_word(CMD_INSERT, 17'd100, 10'd3);
        send_word(CMD_INSERT, 17'd100, 10'd4);
        send_word(CMD_INSERT, 17'd50, 10'd6);
        send_word(CMD_DELETE, '0, 10'd3);
        send_word(CMD_DELETE, '0, 10'd3);
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_DELETE, '0, 10'd0);
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_INSERT, 17'h15555, 10'h155);
        send_word(CMD_INSERT, 17'h0aaaa, 10'h2aa);
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_EXTRACT, '0, '0);
        send_word(CMD_EXTRACT, '0, '0);

        // Random mix. Handles come mostly from a narrow window so that deletes
        // and duplicates hit often and the heap stays modest in size.
        hold_off_request = 1;
        for (int n = 0; n < 480; n++) begin
            r = $urandom_range(0, 99);
            h = ($urandom_range(0, 4) == 0) ? HANDLE_W'($urandom_range(0, 1023))
                                            : HANDLE_W'($urandom_range(0, 63));
            if (r < 48)
                send_word(CMD_INSERT, VALUE_BITS'($urandom_range(0, 131071)), h);
            else if (r < 70)
                send_word(CMD_EXTRACT, VALUE_BITS'($urandom), HANDLE_W'($urandom));
            else if (r < 97)
                send_word(CMD_DELETE, VALUE_BITS'($urandom), h);
            else
                send_word(CMD_UNUSED, VALUE_BITS'($urandom), HANDLE_W'($urandom));
        end

        // Drain part of what is left, down to an empty heap where it is small.
        for (int n = 0; n < 50; n++)
            send_word(CMD_EXTRACT, '0, '0);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("indexed_max_heap_queue regression: pass");
        else
            $display("indexed_max_heap_queue regression: fail");
        $finish;
    end

endmodule
